### rtl/core/gpr_pkg.sv
// Shared types and constants for the gamepad packet receiver.
// No dependencies; used by gpr_regs, gpr_deframer and gamepad_packet_receiver.
`timescale 1ns / 1ps

package gpr_pkg;

    // Item kinds carried in s_tuser
    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } gpr_op_t;

    // Deframer state: hunting for a header, or collecting announced bytes
    typedef enum logic {
        ST_HUNT = 1'b0,
        ST_BODY = 1'b1
    } gpr_state_t;

    // Register indexes (byte address 4*index)
    typedef enum logic [1:0] {
        REG_DEADZONE  = 2'd0,
        REG_PKT_TMO   = 2'd1,
        REG_LINK_TMO  = 2'd2,
        REG_UNUSED    = 2'd3
    } gpr_reg_idx_t;

    localparam logic [7:0]  DEADZONE_RESET = 8'd0;
    localparam logic [7:0]  PKT_TMO_RESET  = 8'd5;
    localparam logic [15:0] LINK_TMO_RESET = 16'd1000;

    localparam logic [7:0] HEADER_RESERVED = 8'hC0;

    // Target bit positions in the expanded header mask
    localparam int TGT_LB = 6;
    localparam int TGT_RB = 7;

    typedef struct packed {
        logic [15:0] link_timeout;
        logic [7:0]  pkt_timeout;
        logic [7:0]  deadzone;
    } gpr_cfg_t;

    // Controller state as it stands after the current word
    typedef struct packed {
        logic [15:0]      idle_ticks;
        logic [3:0][7:0]  stick;
        logic [1:0][7:0]  trigger;
        logic [1:0][7:0]  button;
        logic [1:0][7:0]  click;
        logic             done;
    } gpr_view_t;

endpackage

### rtl/core/gpr_regs.sv
// APB-style configuration registers: deadzone, packet and link timeouts.
// Depends on gpr_pkg.
`timescale 1ns / 1ps

module gpr_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output gpr_pkg::gpr_cfg_t cfg
);

    gpr_pkg::gpr_cfg_t cfg_reg;
    gpr_pkg::gpr_cfg_t cfg_next;
    gpr_pkg::gpr_reg_idx_t idx;
    logic wr_en;

    assign pready = 1'b1;
    assign idx    = gpr_pkg::gpr_reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                gpr_pkg::REG_DEADZONE: cfg_next.deadzone     = pwdata[7:0];
                gpr_pkg::REG_PKT_TMO:  cfg_next.pkt_timeout  = pwdata[7:0];
                gpr_pkg::REG_LINK_TMO: cfg_next.link_timeout = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.deadzone     <= gpr_pkg::DEADZONE_RESET;
            cfg_reg.pkt_timeout  <= gpr_pkg::PKT_TMO_RESET;
            cfg_reg.link_timeout <= gpr_pkg::LINK_TMO_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (idx)
            gpr_pkg::REG_DEADZONE: prdata = {24'd0, cfg_reg.deadzone};
            gpr_pkg::REG_PKT_TMO:  prdata = {24'd0, cfg_reg.pkt_timeout};
            gpr_pkg::REG_LINK_TMO: prdata = {16'd0, cfg_reg.link_timeout};
            default:               prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/gpr_stick.sv
// Stick scaling: raw byte v to 2v-255, zeroed inside the deadzone.
// Depends on nothing but its ports.
`timescale 1ns / 1ps

module gpr_stick (
    input  logic [7:0]        raw,
    input  logic [7:0]        deadzone,
    output logic signed [8:0] scaled
);

    logic signed [9:0] s10;
    logic [9:0]        mag10;
    logic [7:0]        mag;

    assign s10   = $signed({1'b0, raw, 1'b0}) - 10'sd255;
    assign mag10 = s10[9] ? 10'(-s10) : 10'(s10);
    assign mag   = mag10[7:0];   // |2v-255| never exceeds 255

    assign scaled = (mag < deadzone) ? 9'sd0 : s10[8:0];

endmodule

### rtl/core/gpr_deframer.sv
// Header hunt, byte steering, timeouts and click tracking.
// Depends on gpr_pkg. Presents the state after the current word.
`timescale 1ns / 1ps

module gpr_deframer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  gpr_pkg::gpr_op_t   op,
    input  logic [7:0]         data_byte,
    input  logic               clear_side,
    input  logic [7:0]         clear_mask,
    input  gpr_pkg::gpr_cfg_t  cfg,
    output gpr_pkg::gpr_view_t view_next
);

    gpr_pkg::gpr_state_t state_reg, state_next;
    logic [7:0]       remaining_reg, remaining_next;  // targets still to come
    logic [7:0]       packet_age_reg, packet_age_next;
    logic [15:0]      idle_ticks_reg, idle_ticks_next;
    logic [3:0][7:0]  stick_reg, stick_next;
    logic [1:0][7:0]  trigger_reg, trigger_next;
    logic [1:0][7:0]  button_reg, button_next;
    logic [1:0][7:0]  click_reg, click_next;

    logic       is_byte, is_tick, is_clear;
    logic       hdr_ok;
    logic [7:0] hdr_mask;
    logic [7:0] tgt;          // one-hot current target
    logic [7:0] rem_after;
    logic [7:0] age_inc;
    logic       done;

    assign is_byte  = accept && (op == gpr_pkg::OP_BYTE);
    assign is_tick  = accept && (op == gpr_pkg::OP_TICK);
    assign is_clear = accept && (op == gpr_pkg::OP_CLEAR);

    assign hdr_ok   = (data_byte != 8'd0) && ((data_byte & gpr_pkg::HEADER_RESERVED) == 8'd0);
    // sticks take two bytes each, then triggers, then button bytes
    assign hdr_mask = {data_byte[5], data_byte[4], data_byte[3], data_byte[2],
                       data_byte[1], data_byte[1], data_byte[0], data_byte[0]};

    assign tgt       = remaining_reg & (~remaining_reg + 8'd1);
    assign rem_after = remaining_reg & ~tgt;
    assign age_inc   = (packet_age_reg == 8'hFF) ? packet_age_reg : packet_age_reg + 8'd1;
    assign done      = is_byte && (state_reg == gpr_pkg::ST_BODY) && (rem_after == 8'd0);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gpr_pkg::ST_HUNT: begin
                if (is_byte && hdr_ok) state_next = gpr_pkg::ST_BODY;
            end
            gpr_pkg::ST_BODY: begin
                if (done) begin
                    state_next = gpr_pkg::ST_HUNT;
                end else if (is_tick && (age_inc >= cfg.pkt_timeout)) begin
                    state_next = gpr_pkg::ST_HUNT;
                end
            end
            default: state_next = gpr_pkg::ST_HUNT;
        endcase
    end

    // datapath
    always_comb begin
        remaining_next  = remaining_reg;
        packet_age_next = packet_age_reg;
        idle_ticks_next = idle_ticks_reg;
        stick_next      = stick_reg;
        trigger_next    = trigger_reg;
        button_next     = button_reg;
        click_next      = click_reg;

        if (is_byte) begin
            idle_ticks_next = 16'd0;
            if (state_reg == gpr_pkg::ST_HUNT) begin
                if (hdr_ok) begin
                    remaining_next  = hdr_mask;
                    packet_age_next = 8'd0;
                end
            end else begin
                remaining_next = rem_after;
                for (int i = 0; i < 4; i++) begin
                    if (tgt[i]) stick_next[i] = data_byte;
                end
                for (int i = 0; i < 2; i++) begin
                    if (tgt[4 + i]) trigger_next[i] = data_byte;
                end
                for (int i = 0; i < 2; i++) begin
                    if (tgt[gpr_pkg::TGT_LB + i]) begin
                        click_next[i]  = data_byte & ~button_reg[i];
                        button_next[i] = data_byte;
                    end
                end
            end
        end else if (is_tick) begin
            if (idle_ticks_reg != 16'hFFFF) idle_ticks_next = idle_ticks_reg + 16'd1;
            if (state_reg == gpr_pkg::ST_BODY) packet_age_next = age_inc;
        end else if (is_clear) begin
            click_next[clear_side] = click_reg[clear_side] & ~clear_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= gpr_pkg::ST_HUNT;
            remaining_reg  <= 8'd0;
            packet_age_reg <= 8'd0;
            idle_ticks_reg <= gpr_pkg::LINK_TMO_RESET;
            stick_reg      <= '0;
            trigger_reg    <= '0;
            button_reg     <= '0;
            click_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            remaining_reg  <= remaining_next;
            packet_age_reg <= packet_age_next;
            idle_ticks_reg <= idle_ticks_next;
            stick_reg      <= stick_next;
            trigger_reg    <= trigger_next;
            button_reg     <= button_next;
            click_reg      <= click_next;
        end
    end

    always_comb begin
        view_next.idle_ticks = idle_ticks_next;
        view_next.stick      = stick_next;
        view_next.trigger    = trigger_next;
        view_next.button     = button_next;
        view_next.click      = click_next;
        view_next.done       = done;
    end

    // a packet in progress always has at least one byte left to collect
    a_body_has_targets: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gpr_pkg::ST_BODY) |-> (remaining_reg != 8'd0))
        else $error("body state with no targets left");

    a_byte_clears_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && is_byte) |=> (idle_ticks_reg == 16'd0))
        else $error("received byte did not clear idle counter");

    a_header_starts_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && is_byte && (state_reg == gpr_pkg::ST_HUNT) && hdr_ok)
        |=> ((state_reg == gpr_pkg::ST_BODY) && (packet_age_reg == 8'd0)))
        else $error("valid header did not open a packet");

    a_done_only_in_body: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (state_reg == gpr_pkg::ST_BODY && state_next == gpr_pkg::ST_HUNT))
        else $error("packet end outside a packet");

endmodule

### rtl/core/gamepad_packet_receiver.sv
// Gamepad packet receiver: one result word per accepted input word.
// The result word is registered at the accepting edge and is valid in the cycle after acceptance.
// Throughput: one word per cycle; s_tready drops only while a result waits unread.
// Reset (aresetn low, synchronous): no packet open, all controller state zero,
// link down (idle count at 1000), registers at deadzone 0 / packet 5 / link 1000.
// Depends on gpr_pkg, gpr_regs, gpr_stick, gpr_deframer.
`timescale 1ns / 1ps

module gamepad_packet_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte[7:0], clear_side[8], clear_mask[16:9]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // link_up[0], left_x[9:1], left_y[18:10],
                                   // right_x[27:19], right_y[36:28],
                                   // left_trig[44:37], right_trig[52:45],
                                   // left_pressed[60:53], right_pressed[68:61],
                                   // left_clicked[76:69], right_clicked[84:77]
    output logic        m_tlast    // packet_done
);

    gpr_pkg::gpr_cfg_t  cfg;
    gpr_pkg::gpr_view_t view_next;
    logic               s_accept;
    logic               link_up;
    logic signed [8:0]  stick_scaled [4];

    logic        m_tvalid_reg, m_tvalid_next;
    logic [87:0] m_tdata_reg;
    logic        m_tlast_reg;

    gpr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    gpr_deframer u_deframer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .op         (gpr_pkg::gpr_op_t'(s_tuser)),
        .data_byte  (s_tdata[7:0]),
        .clear_side (s_tdata[8]),
        .clear_mask (s_tdata[16:9]),
        .cfg        (cfg),
        .view_next  (view_next)
    );

    for (genvar g = 0; g < 4; g++) begin : g_stick
        gpr_stick u_stick (
            .raw      (view_next.stick[g]),
            .deadzone (cfg.deadzone),
            .scaled   (stick_scaled[g])
        );
    end

    assign link_up = view_next.idle_ticks < cfg.link_timeout;

    assign m_tvalid_next = s_accept ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {3'd0,
                            view_next.click[1], view_next.click[0],
                            view_next.button[1], view_next.button[0],
                            view_next.trigger[1], view_next.trigger[0],
                            stick_scaled[3], stick_scaled[2],
                            stick_scaled[1], stick_scaled[0],
                            link_up};
            m_tlast_reg <= view_next.done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### verif/gpr_checker.sv
// Result checker for gamepad_packet_receiver: mirrors the controller state from
// accepted input words and register writes, and compares every result word.
// Depends on gpr_pkg.
`timescale 1ns / 1ps

module gpr_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte[7:0], clear_side[8], clear_mask[16:9]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,   // link_up, left_x/y, right_x/y, triggers, pressed, clicked
    input  logic        m_tlast,   // packet_done
    output int          pending,
    output int          errors
);

    // Same order as m_tdata from bit 0 up, with packet_done on top
    typedef struct packed {
        logic       done;
        logic [7:0] right_clicked;
        logic [7:0] left_clicked;
        logic [7:0] right_pressed;
        logic [7:0] left_pressed;
        logic [7:0] right_trig;
        logic [7:0] left_trig;
        logic [8:0] right_y;
        logic [8:0] right_x;
        logic [8:0] left_y;
        logic [8:0] left_x;
        logic       link_up;
    } gpr_report_t;

    gpr_pkg::gpr_cfg_t   cfg;
    gpr_pkg::gpr_state_t mode;
    logic [2:0]  slot_target [8];
    logic [3:0]  slot_pos;
    logic [3:0]  slot_count;
    logic [7:0]  pkt_age;
    logic [15:0] idle_cnt;
    logic [7:0]  stick [4];
    logic [7:0]  trig [2];
    logic [7:0]  btn [2];
    logic [7:0]  clicks [2];

    gpr_report_t reports_due [$];
    int mismatches = 0;
    int result_no = 0;

    assign errors = mismatches;

    function automatic void reset_state();
        cfg.deadzone     = gpr_pkg::DEADZONE_RESET;
        cfg.pkt_timeout  = gpr_pkg::PKT_TMO_RESET;
        cfg.link_timeout = gpr_pkg::LINK_TMO_RESET;
        mode       = gpr_pkg::ST_HUNT;
        slot_pos   = '0;
        slot_count = '0;
        pkt_age    = '0;
        idle_cnt   = gpr_pkg::LINK_TMO_RESET;
        for (int i = 0; i < 8; i++) slot_target[i] = '0;
        for (int i = 0; i < 4; i++) stick[i] = '0;
        for (int i = 0; i < 2; i++) begin
            trig[i]   = '0;
            btn[i]    = '0;
            clicks[i] = '0;
        end
    endfunction

    function automatic logic [8:0] stick_value(logic [7:0] raw);
        int s;
        int mag;
        s = 2 * int'(raw) - 255;
        mag = (s < 0) ? -s : s;
        if (mag < int'(cfg.deadzone)) s = 0;
        return s[8:0];
    endfunction

    // Header bit 0 -> sticks 0,1; bit 1 -> sticks 2,3; bits 2..5 -> targets 4..7
    function automatic void take_header(logic [7:0] h);
        int n;
        int hb;
        n = 0;
        for (int t = 0; t < 8; t++) begin
            hb = (t < 4) ? (t >> 1) : (t - 2);
            if (h[hb]) begin
                slot_target[n] = 3'(t);
                n++;
            end
        end
        slot_count = 4'(n);
        slot_pos   = '0;
        pkt_age    = '0;
        mode       = gpr_pkg::ST_BODY;
    endfunction

    function automatic logic take_data(logic [7:0] b);
        logic [2:0] t;
        t = slot_target[slot_pos[2:0]];
        if (t < 3'd4) begin
            stick[t[1:0]] = b;
        end else if (t < 3'd6) begin
            trig[t[0]] = b;
        end else begin
            clicks[t[0]] = b & ~btn[t[0]];
            btn[t[0]]    = b;
        end
        slot_pos++;
        if (slot_pos >= slot_count) begin
            mode = gpr_pkg::ST_HUNT;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic gpr_report_t advance(gpr_pkg::gpr_op_t op, logic [7:0] b, logic side,
                                            logic [7:0] mask);
        gpr_report_t r;
        logic done;
        done = 1'b0;
        case (op)
            gpr_pkg::OP_BYTE: begin
                idle_cnt = '0;
                if (mode == gpr_pkg::ST_BODY)
                    done = take_data(b);
                else if (b != 8'h00 && (b & gpr_pkg::HEADER_RESERVED) == 8'h00)
                    take_header(b);
            end
            gpr_pkg::OP_TICK: begin
                if (idle_cnt != 16'hFFFF) idle_cnt++;
                if (mode == gpr_pkg::ST_BODY) begin
                    if (pkt_age != 8'hFF) pkt_age++;
                    if (pkt_age >= cfg.pkt_timeout) mode = gpr_pkg::ST_HUNT;
                end
            end
            gpr_pkg::OP_CLEAR: clicks[side] = clicks[side] & ~mask;
            default: ;
        endcase
        r.link_up       = (idle_cnt < cfg.link_timeout);
        r.left_x        = stick_value(stick[0]);
        r.left_y        = stick_value(stick[1]);
        r.right_x       = stick_value(stick[2]);
        r.right_y       = stick_value(stick[3]);
        r.left_trig     = trig[0];
        r.right_trig    = trig[1];
        r.left_pressed  = btn[0];
        r.right_pressed = btn[1];
        r.left_clicked  = clicks[0];
        r.right_clicked = clicks[1];
        r.done          = done;
        return r;
    endfunction

    function automatic void match_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            if (mismatches < 10)
                $display("word %0d: %s expected 0x%0h, got 0x%0h", result_no, fname, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        gpr_report_t want;
        gpr_report_t got;
        if (!aresetn) begin
            reset_state();
            reports_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = gpr_report_t'({m_tlast, m_tdata[84:0]});
                if (reports_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("word %0d: result word with none outstanding", result_no);
                    mismatches++;
                end else begin
                    want = reports_due.pop_front();
                    match_field("link_up",       want.link_up,       got.link_up);
                    match_field("left_x",        want.left_x,        got.left_x);
                    match_field("left_y",        want.left_y,        got.left_y);
                    match_field("right_x",       want.right_x,       got.right_x);
                    match_field("right_y",       want.right_y,       got.right_y);
                    match_field("left_trig",     want.left_trig,     got.left_trig);
                    match_field("right_trig",    want.right_trig,    got.right_trig);
                    match_field("left_pressed",  want.left_pressed,  got.left_pressed);
                    match_field("right_pressed", want.right_pressed, got.right_pressed);
                    match_field("left_clicked",  want.left_clicked,  got.left_clicked);
                    match_field("right_clicked", want.right_clicked, got.right_clicked);
                    match_field("packet_done",   want.done,          got.done);
                end
                result_no++;
            end
            if (psel && penable && pwrite && pready) begin
                case (gpr_pkg::gpr_reg_idx_t'(paddr[3:2]))
                    gpr_pkg::REG_DEADZONE: cfg.deadzone     = pwdata[7:0];
                    gpr_pkg::REG_PKT_TMO:  cfg.pkt_timeout  = pwdata[7:0];
                    gpr_pkg::REG_LINK_TMO: cfg.link_timeout = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                reports_due.push_back(advance(gpr_pkg::gpr_op_t'(s_tuser), s_tdata[7:0],
                                              s_tdata[8], s_tdata[16:9]));
        end
        pending <= reports_due.size();
    end

endmodule

### verif/tb_top.sv
// Testbench top for gamepad_packet_receiver: clock, reset, register writes and
// input words (directed packets, then random traffic under several settings).
// Depends on gpr_pkg, the receiver RTL and gpr_checker.
`timescale 1ns / 1ps

module tb_top;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // data_byte[7:0], clear_side[8], clear_mask[16:9]
    logic [1:0]  s_tuser  = '0;   // operation[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;         // link_up, left_x/y, right_x/y, triggers, pressed, clicked
    logic        m_tlast;         // packet_done

    int results_pending;
    int mismatch_count;

    bit gaps_off    = 1'b0;
    bit rx_steady   = 1'b0;
    bit rx_hold_req = 1'b0;
    int words_sent  = 0;

    gamepad_packet_receiver u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    gpr_checker u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .pending  (results_pending),
        .errors   (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Result side: mostly ready, short and occasional long stalls, one forced long hold
    initial begin : rx_side
        int len;
        int r;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                if (rx_steady || r < 60) begin
                    m_tready <= 1'b1;
                    len = $urandom_range(1, 8);
                end else if (r < 94) begin
                    m_tready <= 1'b0;
                    len = $urandom_range(1, 3);
                end else begin
                    m_tready <= 1'b0;
                    len = $urandom_range(10, 40);
                end
                repeat (len) @(posedge aclk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (gaps_off) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 8'h00;
        if (r < 30) return 8'hFF;
        if (r < 40) return $urandom_range(0, 1) ? 8'h80 : 8'h7F;
        return 8'($urandom_range(0, 255));
    endfunction

    // valid stays high across back-to-back words; lowered only for a gap or in wait_idle
    task automatic send_word(gpr_pkg::gpr_op_t op, logic [7:0] b, logic side,
                             logic [7:0] mask);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, mask, side, b};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_word(gpr_pkg::OP_BYTE, b, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_tick();
        send_word(gpr_pkg::OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic send_clear(logic side, logic [7:0] mask);
        send_word(gpr_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), side, mask);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // the bus returns to idle after the access so back-to-back writes never overlap
    task automatic reg_write(gpr_pkg::gpr_reg_idx_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(logic [7:0] dz, logic [7:0] pkt_tmo, logic [15:0] link_tmo);
        wait_idle();
        reg_write(gpr_pkg::REG_DEADZONE, {24'd0, dz});
        reg_write(gpr_pkg::REG_PKT_TMO, {24'd0, pkt_tmo});
        reg_write(gpr_pkg::REG_LINK_TMO, {16'd0, link_tmo});
    endtask

    // Well-formed packet with random content; now and then a tick inside it or
    // a packet cut short and followed by ticks
    task automatic random_packet();
        logic [7:0] hdr;
        int n;
        int cut;
        hdr = 8'($urandom_range(1, 63));
        n = 2 * $countones(hdr[1:0]) + $countones(hdr[5:2]);
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
        send_byte(hdr);
        for (int i = 0; i < cut; i++) begin
            if ($urandom_range(0, 9) == 0) send_tick();
            send_byte(rand_byte());
        end
        if (cut < n) repeat ($urandom_range(0, 6)) send_tick();
    endtask

    task automatic random_traffic(int words);
        int stop;
        int r;
        stop = words_sent + words;
        while (words_sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 65)
                random_packet();
            else if (r < 80)
                repeat ($urandom_range(1, 12)) send_tick();
            else if (r < 92)
                send_clear(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            else if (r < 97)
                send_byte(8'($urandom_range(0, 255)));
            else
                send_word(gpr_pkg::OP_NONE, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: link starts down, unused op, idle clear
        send_tick();
        send_word(gpr_pkg::OP_NONE, 8'hFF, 1'b1, 8'hFF);
        send_clear(1'b1, 8'hFF);
        // dropped while hunting: zero byte and reserved bits set
        send_byte(8'h00);
        send_byte(8'hC1);
        // full packet with stick extremes
        send_byte(8'h3F);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_byte(8'h5A);
        // buttons only: clicks are new AND NOT old
        send_byte(8'h30);
        send_byte(8'hFF);
        send_byte(8'h0F);
        send_clear(1'b0, 8'h0F);
        // header-like byte inside a packet is data
        send_byte(8'h01);
        send_byte(8'h3F);
        send_byte(8'h01);
        // unfinished packet abandoned by the packet timeout
        send_byte(8'h02);
        repeat (5) send_tick();

        configure(8'd255, 8'd255, 16'd65535);
        random_traffic(60);

        configure(8'd0, 8'd1, 16'd1);
        random_traffic(30);
        // long hold on the result side while words keep coming
        gaps_off = 1'b1;
        rx_hold_req = 1'b1;
        random_traffic(30);
        gaps_off = 1'b0;

        // zero packet timeout drops a packet on its first tick
        configure(8'd128, 8'd0, 16'd3);
        random_traffic(60);

        configure(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)),
                  16'($urandom_range(2, 20)));
        gaps_off = 1'b1;
        rx_steady = 1'b1;
        random_traffic(60);
        gaps_off = 1'b0;
        rx_steady = 1'b0;

        configure(8'd1, 8'd2, 16'd8);
        random_traffic(30);
        wait_idle();
        random_traffic(30);

        configure(8'($urandom_range(0, 255)), 8'd5, 16'd1000);
        random_traffic(60);

        wait_idle();
        repeat (5) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
rtl/core/gpr_pkg.sv
rtl/core/gpr_regs.sv
rtl/core/gpr_stick.sv
rtl/core/gpr_deframer.sv
rtl/core/gamepad_packet_receiver.sv
verif/gpr_checker.sv
verif/tb_top.sv
